@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion forms for the ring cursor tracker checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with explicit clock and active-low reset
`define ARCT_ASSERT_CLK(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (prop)) \
		else $error(msg);

// assertion on the default clk / arst_n pair
`define ARCT_ASSERT(label, prop, msg) `ARCT_ASSERT_CLK(label, clk, arst_n, prop, msg)

`endif

@@ rtl/core/arct_pkg.sv @@
// ----------------------------------------------------------------------------
// arct_pkg
// Widths, codes and control structs of the audio ring cursor tracker.
// ----------------------------------------------------------------------------
package arct_pkg;

	localparam int unsigned MAX_RING_DEF = 1048576;

	localparam int unsigned CMD_W   = 2;
	localparam int unsigned CUR_W   = 20;
	localparam int unsigned RCFG_W  = 21;
	localparam int unsigned FRM_W   = 9;
	localparam int unsigned DIR_W   = 1;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned CNT_W   = 21;
	localparam int unsigned TOT_W   = 64;
	localparam int unsigned PADDR_W = 4;
	localparam int unsigned PDATA_W = 32;
	localparam int unsigned RIDX_W  = 2;

	// serial divider
	localparam int unsigned DIV_R_W = 21;
	localparam int unsigned DIV_Q_W = 22;
	localparam int unsigned DIV_N_W = 6;
	localparam int unsigned DIV_BPC = 2;
	localparam int unsigned DSEL_W  = 3;

	localparam logic [DIV_N_W-1:0] DIV_N_CUR = DIV_N_W'(CUR_W / DIV_BPC);
	localparam logic [DIV_N_W-1:0] DIV_N_TOT = DIV_N_W'(TOT_W / DIV_BPC);
	localparam logic [DIV_N_W-1:0] DIV_N_CNT = DIV_N_W'(DIV_Q_W / DIV_BPC);

	localparam logic [CMD_W-1:0] CMD_POLL    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PREFILL = 2'd1;
	localparam logic [CMD_W-1:0] CMD_STOP    = 2'd2;

	localparam logic [STAT_W-1:0] STAT_NONE = 2'd0;
	localparam logic [STAT_W-1:0] STAT_XFER = 2'd1;
	localparam logic [STAT_W-1:0] STAT_LOST = 2'd2;

	localparam logic [RIDX_W-1:0] REG_RING  = 2'd0;
	localparam logic [RIDX_W-1:0] REG_FRAME = 2'd1;
	localparam logic [RIDX_W-1:0] REG_DIR   = 2'd2;

	localparam logic [RCFG_W-1:0] RING_RST  = 21'd1048576;
	localparam logic [FRM_W-1:0]  FRAME_RST = 9'd4;
	localparam logic [DIR_W-1:0]  DIR_RST   = 1'b1;

	localparam logic [DSEL_W-1:0] DSEL_RD   = 3'd0;
	localparam logic [DSEL_W-1:0] DSEL_WR   = 3'd1;
	localparam logic [DSEL_W-1:0] DSEL_PREV = 3'd2;
	localparam logic [DSEL_W-1:0] DSEL_SW   = 3'd3;
	localparam logic [DSEL_W-1:0] DSEL_FRM  = 3'd4;

	typedef struct packed {
		logic              load_in;
		logic              res_clr;
		logic              clr_tot;
		logic              prefill;
		logic              div_start;
		logic [DSEL_W-1:0] div_sel;
		logic              hw_upd;
		logic              diff_calc;
		logic              avail_calc;
		logic              flag_calc;
		logic              decide;
		logic              out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             dir;
		logic             div_done;
		logic             xfer;
		logic             out_free;
	} dp_stat_t;

endpackage

@@ rtl/core/arct_if.sv @@
// ----------------------------------------------------------------------------
// arct_in_if / arct_out_if
// Valid/ready channels for cursor requests and tracker results.
// ----------------------------------------------------------------------------
interface arct_in_if;
	logic                        valid;
	logic                        ready;
	logic [arct_pkg::CMD_W-1:0]  cmd;
	logic [arct_pkg::CUR_W-1:0]  read_cursor;
	logic [arct_pkg::CUR_W-1:0]  write_cursor;

	modport source (output valid, cmd, read_cursor, write_cursor, input ready);
	modport sink   (input valid, cmd, read_cursor, write_cursor, output ready);
endinterface

interface arct_out_if;
	logic                        valid;
	logic                        ready;
	logic [arct_pkg::STAT_W-1:0] status;
	logic [arct_pkg::CUR_W-1:0]  lock_offset;
	logic [arct_pkg::CNT_W-1:0]  transfer_bytes;
	logic [arct_pkg::CNT_W-1:0]  transfer_frames;
	logic [arct_pkg::CNT_W-1:0]  first_part_bytes;
	logic [arct_pkg::CNT_W-1:0]  second_part_bytes;

	modport source (output valid, status, lock_offset, transfer_bytes, transfer_frames,
		first_part_bytes, second_part_bytes, input ready);
	modport sink   (input valid, status, lock_offset, transfer_bytes, transfer_frames,
		first_part_bytes, second_part_bytes, output ready);
endinterface

@@ rtl/core/arct_div.sv @@
// ----------------------------------------------------------------------------
// arct_div
// Serial restoring divider, two quotient bits per cycle, left-aligned dividend.
// ----------------------------------------------------------------------------
module arct_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [arct_pkg::TOT_W-1:0]        dividend,
	input  logic [arct_pkg::DIV_R_W-1:0]      divisor,
	input  logic [arct_pkg::DIV_N_W-1:0]      steps,
	output logic                              done,
	output logic [arct_pkg::DIV_R_W-1:0]      rem,
	output logic [arct_pkg::DIV_Q_W-1:0]      quot
);
	localparam int unsigned TW = arct_pkg::TOT_W;
	localparam int unsigned RW = arct_pkg::DIV_R_W;
	localparam int unsigned QW = arct_pkg::DIV_Q_W;
	localparam int unsigned NW = arct_pkg::DIV_N_W;

	logic          busy_q;
	logic          done_q;
	logic [NW-1:0] cnt_q;
	logic [TW-1:0] d_q;
	logic [RW-1:0] r_q;
	logic [RW-1:0] div_q;
	logic [QW-1:0] q_q;
	logic [TW-1:0] d_n;
	logic [RW-1:0] r_n;
	logic [QW-1:0] q_n;

	always_comb begin
		logic [RW:0] r2;
		d_n = d_q;
		r_n = r_q;
		q_n = q_q;
		for (int j = 0; j < arct_pkg::DIV_BPC; j++) begin
			r2  = {r_n, d_n[TW-1]};
			d_n = {d_n[TW-2:0], 1'b0};
			if (r2 >= {1'b0, div_q}) begin
				r_n = RW'(r2 - {1'b0, div_q});
				q_n = {q_n[QW-2:0], 1'b1};
			end else begin
				r_n = r2[RW-1:0];
				q_n = {q_n[QW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - NW'(1);
				if (cnt_q == NW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			d_q   <= dividend;
			r_q   <= '0;
			q_q   <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			d_q <= d_n;
			r_q <= r_n;
			q_q <= q_n;
		end
	end

	assign done = done_q;
	assign rem  = r_q;
	assign quot = q_q;

endmodule

@@ rtl/core/arct_cfg.sv @@
// ----------------------------------------------------------------------------
// arct_cfg
// APB register file: ring size, frame size and direction, with clamping.
// ----------------------------------------------------------------------------
module arct_cfg #(
	parameter int unsigned MAX_RING_BYTES = arct_pkg::MAX_RING_DEF,
	parameter int unsigned RING_W         = arct_pkg::RCFG_W
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [arct_pkg::PADDR_W-1:0]   paddr,
	input  logic [arct_pkg::PDATA_W-1:0]   pwdata,
	output logic [arct_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	output logic [RING_W-1:0]              ring_eff,
	output logic [arct_pkg::FRM_W-1:0]     fsz_eff,
	output logic                           dir_eff
);
	localparam int unsigned DW = arct_pkg::PDATA_W;
	localparam int unsigned CW = arct_pkg::RCFG_W;
	localparam int unsigned FW = arct_pkg::FRM_W;
	localparam logic [DW-1:0] MAX_W = DW'(MAX_RING_BYTES);

	logic [CW-1:0]               ring_q;
	logic [FW-1:0]               frame_q;
	logic                        dir_q;
	logic [arct_pkg::RIDX_W-1:0] idx;
	logic                        wr_en;

	assign idx    = paddr[arct_pkg::PADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_q  <= arct_pkg::RING_RST;
			frame_q <= arct_pkg::FRAME_RST;
			dir_q   <= arct_pkg::DIR_RST;
		end else if (wr_en) begin
			case (idx)
				arct_pkg::REG_RING:  ring_q  <= pwdata[CW-1:0];
				arct_pkg::REG_FRAME: frame_q <= pwdata[FW-1:0];
				arct_pkg::REG_DIR:   dir_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			arct_pkg::REG_RING:  prdata = DW'(ring_q);
			arct_pkg::REG_FRAME: prdata = DW'(frame_q);
			arct_pkg::REG_DIR:   prdata = DW'(dir_q);
			default:             prdata = '0;
		endcase
	end

	always_comb begin
		if (ring_q == '0) begin
			ring_eff = RING_W'(1);
		end else if (DW'(ring_q) > MAX_W) begin
			ring_eff = RING_W'(MAX_W);
		end else begin
			ring_eff = RING_W'(ring_q);
		end
	end

	assign fsz_eff = (frame_q == '0) ? FW'(1) : frame_q;
	assign dir_eff = dir_q;

endmodule

@@ rtl/core/arct_ctrl.sv @@
// ----------------------------------------------------------------------------
// arct_ctrl
// Sequencer: steps the datapath through reductions, totals, the decision and frame count, or prefill and stop.
// ----------------------------------------------------------------------------
module arct_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  arct_pkg::dp_stat_t stat,
	output arct_pkg::dp_cmd_t  cmd
);
	localparam int unsigned SW = 4;
	localparam logic [SW-1:0] S_IDLE = 4'd0;
	localparam logic [SW-1:0] S_DEC  = 4'd1;
	localparam logic [SW-1:0] S_MRD  = 4'd2;
	localparam logic [SW-1:0] S_MWR  = 4'd3;
	localparam logic [SW-1:0] S_MPRV = 4'd4;
	localparam logic [SW-1:0] S_MSW  = 4'd5;
	localparam logic [SW-1:0] S_HW   = 4'd6;
	localparam logic [SW-1:0] S_DIFF = 4'd7;
	localparam logic [SW-1:0] S_AVL  = 4'd8;
	localparam logic [SW-1:0] S_FLG  = 4'd9;
	localparam logic [SW-1:0] S_DCD  = 4'd10;
	localparam logic [SW-1:0] S_FGO  = 4'd11;
	localparam logic [SW-1:0] S_FRM  = 4'd12;
	localparam logic [SW-1:0] S_DONE = 4'd13;

	logic [SW-1:0] state_q;
	logic [SW-1:0] state_n;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_n     = S_DEC;
				end
			end
			S_DEC: begin
				cmd.res_clr = 1'b1;
				case (stat.cmd)
					arct_pkg::CMD_POLL: begin
						cmd.div_start = 1'b1;
						cmd.div_sel   = arct_pkg::DSEL_RD;
						state_n       = S_MRD;
					end
					arct_pkg::CMD_PREFILL: begin
						if (stat.dir) begin
							cmd.prefill = 1'b1;
							state_n     = S_FGO;
						end else begin
							state_n = S_DONE;
						end
					end
					arct_pkg::CMD_STOP: begin
						cmd.clr_tot = 1'b1;
						state_n     = S_DONE;
					end
					default: state_n = S_DONE;
				endcase
			end
			S_MRD: begin
				if (stat.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = arct_pkg::DSEL_WR;
					state_n       = S_MWR;
				end
			end
			S_MWR: begin
				if (stat.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = arct_pkg::DSEL_PREV;
					state_n       = S_MPRV;
				end
			end
			S_MPRV: begin
				if (stat.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = arct_pkg::DSEL_SW;
					state_n       = S_MSW;
				end
			end
			S_MSW: begin
				if (stat.div_done) begin
					state_n = S_HW;
				end
			end
			S_HW: begin
				cmd.hw_upd = 1'b1;
				state_n    = S_DIFF;
			end
			S_DIFF: begin
				cmd.diff_calc = 1'b1;
				state_n       = S_AVL;
			end
			S_AVL: begin
				cmd.avail_calc = 1'b1;
				state_n        = S_FLG;
			end
			S_FLG: begin
				cmd.flag_calc = 1'b1;
				state_n       = S_DCD;
			end
			S_DCD: begin
				cmd.decide = 1'b1;
				state_n    = stat.xfer ? S_FGO : S_DONE;
			end
			S_FGO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = arct_pkg::DSEL_FRM;
				state_n       = S_FRM;
			end
			S_FRM: begin
				if (stat.div_done) begin
					state_n = S_DONE;
				end
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

@@ rtl/core/arct_dp.sv @@
// ----------------------------------------------------------------------------
// arct_dp
// Datapath: cursor reduction, byte totals, availability, split and result reg.
// ----------------------------------------------------------------------------
module arct_dp #(
	parameter int unsigned RING_W = arct_pkg::RCFG_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  arct_pkg::dp_cmd_t             cmd,
	output arct_pkg::dp_stat_t            stat,
	input  logic [arct_pkg::CMD_W-1:0]    in_cmd,
	input  logic [arct_pkg::CUR_W-1:0]    in_rd,
	input  logic [arct_pkg::CUR_W-1:0]    in_wr,
	input  logic [RING_W-1:0]             ring_eff,
	input  logic [arct_pkg::FRM_W-1:0]    fsz_eff,
	input  logic                          dir_eff,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [arct_pkg::STAT_W-1:0]   out_status,
	output logic [arct_pkg::CUR_W-1:0]    out_lock,
	output logic [arct_pkg::CNT_W-1:0]    out_bytes,
	output logic [arct_pkg::CNT_W-1:0]    out_frames,
	output logic [arct_pkg::CNT_W-1:0]    out_first,
	output logic [arct_pkg::CNT_W-1:0]    out_second
);
	localparam int unsigned CW = arct_pkg::CUR_W;
	localparam int unsigned TW = arct_pkg::TOT_W;
	localparam int unsigned RW = arct_pkg::DIV_R_W;
	localparam int unsigned QW = arct_pkg::DIV_Q_W;
	localparam int unsigned NW = arct_pkg::DIV_N_W;
	localparam int unsigned BW = arct_pkg::CNT_W;

	function automatic logic [RW-1:0] ring_diff(input logic [CW-1:0] a,
		input logic [CW-1:0] b, input logic [RW-1:0] r);
		logic [RW-1:0] t;
		if (a >= b) begin
			t = RW'(a) - RW'(b);
		end else begin
			t = RW'(a) + r - RW'(b);
		end
		return t;
	endfunction

	function automatic logic in_gap(input logic [RW-1:0] rd, input logic [RW-1:0] wr,
		input logic [RW-1:0] l);
		logic hit;
		if (rd < wr) begin
			hit = (rd <= l) && (l < wr);
		end else if (rd > wr) begin
			hit = (rd <= l) || (l < wr);
		end else begin
			hit = 1'b0;
		end
		return hit;
	endfunction

	// request and config snapshot
	logic [arct_pkg::CMD_W-1:0]  cmd_q;
	logic [CW-1:0]               rdr_q;
	logic [CW-1:0]               wrr_q;
	logic [RING_W-1:0]           ring_q;
	logic [arct_pkg::FRM_W-1:0]  fsz_q;
	logic                        dir_q;
	// working values
	logic [CW-1:0]               rd_q;
	logic [CW-1:0]               wr_q;
	logic [CW-1:0]               prevm_q;
	logic [RW-1:0]               gap_q;
	logic [TW-1:0]               diff_q;
	logic [TW-1:0]               k_q;
	logic [TW-1:0]               avail_q;
	logic                        pos_q;
	logic                        over_q;
	logic                        ingap_q;
	logic [BW-1:0]               take_q;
	logic [arct_pkg::DSEL_W-1:0] dsel_q;
	// tracker state
	logic [TW-1:0]               hw_q;
	logic [TW-1:0]               sw_q;
	logic [CW-1:0]               prev_q;
	// result
	logic [arct_pkg::STAT_W-1:0] status_q;
	logic [RW-1:0]               lock_q;
	logic [BW-1:0]               bytes_q;
	logic [BW-1:0]               frames_q;
	logic [BW-1:0]               first_q;
	logic [BW-1:0]               second_q;
	// output register
	logic                        ovalid_q;
	logic [arct_pkg::STAT_W-1:0] ostatus_q;
	logic [CW-1:0]               olock_q;
	logic [BW-1:0]               obytes_q;
	logic [BW-1:0]               oframes_q;
	logic [BW-1:0]               ofirst_q;
	logic [BW-1:0]               osecond_q;

	logic [RW-1:0]               ring_r;
	logic [CW-1:0]               lead;
	logic [BW-1:0]               avail_b;
	logic [BW-1:0]               first_b;
	logic                        xfer;
	logic [TW-1:0]               div_dvd;
	logic [RW-1:0]               div_dvs;
	logic [NW-1:0]               div_steps;
	logic                        div_done;
	logic [RW-1:0]               div_rem;
	logic [QW-1:0]               div_quot;

	assign ring_r  = RW'(ring_q);
	assign lead    = dir_q ? rd_q : wr_q;
	assign avail_b = avail_q[BW-1:0];
	assign first_b = (take_q < avail_b) ? take_q : avail_b;
	assign xfer    = pos_q & ~over_q & ~ingap_q;

	always_comb begin
		div_dvs   = ring_r;
		div_steps = arct_pkg::DIV_N_CUR;
		case (cmd.div_sel)
			arct_pkg::DSEL_RD:   div_dvd = {rdr_q, {(TW-CW){1'b0}}};
			arct_pkg::DSEL_WR:   div_dvd = {wrr_q, {(TW-CW){1'b0}}};
			arct_pkg::DSEL_PREV: div_dvd = {prev_q, {(TW-CW){1'b0}}};
			arct_pkg::DSEL_SW: begin
				div_dvd   = sw_q;
				div_steps = arct_pkg::DIV_N_TOT;
			end
			arct_pkg::DSEL_FRM: begin
				div_dvd   = {QW'(bytes_q), {(TW-QW){1'b0}}};
				div_dvs   = RW'(fsz_q);
				div_steps = arct_pkg::DIV_N_CNT;
			end
			default: div_dvd = '0;
		endcase
	end

	arct_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.steps    (div_steps),
		.done     (div_done),
		.rem      (div_rem),
		.quot     (div_quot)
	);

	// totals and previous cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q   <= '0;
			sw_q   <= '0;
			prev_q <= '0;
		end else if (cmd.clr_tot) begin
			hw_q   <= '0;
			sw_q   <= '0;
			prev_q <= '0;
		end else if (cmd.hw_upd) begin
			hw_q   <= hw_q + TW'(ring_diff(lead, prevm_q, ring_r));
			prev_q <= lead;
		end else if (cmd.prefill) begin
			sw_q <= sw_q + TW'(ring_r);
		end else if (cmd.decide && xfer) begin
			sw_q <= sw_q + avail_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q  <= in_cmd;
			rdr_q  <= in_rd;
			wrr_q  <= in_wr;
			ring_q <= ring_eff;
			fsz_q  <= fsz_eff;
			dir_q  <= dir_eff;
		end
		if (cmd.div_start) begin
			dsel_q <= cmd.div_sel;
		end
		if (div_done) begin
			case (dsel_q)
				arct_pkg::DSEL_RD:   rd_q     <= div_rem[CW-1:0];
				arct_pkg::DSEL_WR:   wr_q     <= div_rem[CW-1:0];
				arct_pkg::DSEL_PREV: prevm_q  <= div_rem[CW-1:0];
				arct_pkg::DSEL_SW:   lock_q   <= div_rem;
				arct_pkg::DSEL_FRM:  frames_q <= div_quot[BW-1:0];
				default: ;
			endcase
		end
		if (cmd.hw_upd) begin
			gap_q <= ring_diff(wr_q, rd_q, ring_r);
		end
		if (cmd.diff_calc) begin
			diff_q <= hw_q - sw_q;
			k_q    <= dir_q ? TW'(ring_r - gap_q) : TW'(0) - TW'(gap_q);
		end
		if (cmd.avail_calc) begin
			avail_q <= diff_q + k_q;
		end
		if (cmd.flag_calc) begin
			pos_q   <= (avail_q != '0) && !avail_q[TW-1];
			over_q  <= avail_q > TW'(ring_r);
			ingap_q <= in_gap(RW'(rd_q), RW'(wr_q), lock_q);
			take_q  <= BW'(ring_r) - BW'(lock_q);
		end
		if (cmd.prefill) begin
			status_q <= arct_pkg::STAT_XFER;
			lock_q   <= '0;
			bytes_q  <= BW'(ring_r);
			frames_q <= '0;
			first_q  <= BW'(ring_r);
			second_q <= '0;
		end else if (cmd.res_clr) begin
			status_q <= arct_pkg::STAT_NONE;
			lock_q   <= '0;
			bytes_q  <= '0;
			frames_q <= '0;
			first_q  <= '0;
			second_q <= '0;
		end else if (cmd.decide) begin
			if (!pos_q) begin
				status_q <= arct_pkg::STAT_NONE;
			end else if (!xfer) begin
				status_q <= arct_pkg::STAT_LOST;
			end else begin
				status_q <= arct_pkg::STAT_XFER;
				bytes_q  <= avail_b;
				first_q  <= first_b;
				second_q <= avail_b - first_b;
			end
		end
		if (cmd.out_load) begin
			ostatus_q <= status_q;
			olock_q   <= lock_q[CW-1:0];
			obytes_q  <= bytes_q;
			oframes_q <= frames_q;
			ofirst_q  <= first_q;
			osecond_q <= second_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	assign stat.cmd      = cmd_q;
	assign stat.dir      = dir_q;
	assign stat.div_done = div_done;
	assign stat.xfer     = xfer;
	assign stat.out_free = ~ovalid_q | out_ready;

	assign out_valid  = ovalid_q;
	assign out_status = ostatus_q;
	assign out_lock   = olock_q;
	assign out_bytes  = obytes_q;
	assign out_frames = oframes_q;
	assign out_first  = ofirst_q;
	assign out_second = osecond_q;

endmodule

@@ rtl/core/audio_ring_cursor_tracker.sv @@
// Poll requests pass the shared 2-bit/cycle divider (three cursor
// reductions, the 64-bit lock modulo and, for a transfer, the frame count);
// a prefill with direction set divides only for the frame count; other
// prefills, stop and ignored codes skip it; a stalled output adds its wait.
// Throughput: one request in flight; the next is taken once its result enters the
// output register. Async reset clears totals and cursor and loads register defaults.
// ----------------------------------------------------------------------------
// audio_ring_cursor_tracker
// Ring buffer cursor tracking with APB configuration and valid/ready channels.
// ----------------------------------------------------------------------------
module audio_ring_cursor_tracker #(
	parameter int unsigned MAX_RING_BYTES = arct_pkg::MAX_RING_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	arct_in_if.sink                        in_ch,
	arct_out_if.source                     out_ch,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [arct_pkg::PADDR_W-1:0]   paddr,
	input  logic [arct_pkg::PDATA_W-1:0]   pwdata,
	output logic [arct_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready
);
	localparam int unsigned RING_W =
		($clog2(MAX_RING_BYTES + 1) < arct_pkg::RCFG_W) ? $clog2(MAX_RING_BYTES + 1)
		: arct_pkg::RCFG_W;

	logic [RING_W-1:0]          ring_eff;
	logic [arct_pkg::FRM_W-1:0] fsz_eff;
	logic                       dir_eff;
	logic                       in_ready;
	arct_pkg::dp_cmd_t          dp_cmd;
	arct_pkg::dp_stat_t         dp_stat;

	arct_cfg #(
		.MAX_RING_BYTES (MAX_RING_BYTES),
		.RING_W         (RING_W)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.ring_eff (ring_eff),
		.fsz_eff  (fsz_eff),
		.dir_eff  (dir_eff)
	);

	arct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	assign in_ch.ready = in_ready;

	arct_dp #(
		.RING_W (RING_W)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (dp_cmd),
		.stat       (dp_stat),
		.in_cmd     (in_ch.cmd),
		.in_rd      (in_ch.read_cursor),
		.in_wr      (in_ch.write_cursor),
		.ring_eff   (ring_eff),
		.fsz_eff    (fsz_eff),
		.dir_eff    (dir_eff),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.out_status (out_ch.status),
		.out_lock   (out_ch.lock_offset),
		.out_bytes  (out_ch.transfer_bytes),
		.out_frames (out_ch.transfer_frames),
		.out_first  (out_ch.first_part_bytes),
		.out_second (out_ch.second_part_bytes)
	);

endmodule

@@ rtl/core/arct_chk.sv @@
// ----------------------------------------------------------------------------
// arct_chk
// Port-level checks on result fields and request sequencing, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module arct_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [arct_pkg::STAT_W-1:0]   status,
	input logic [arct_pkg::CNT_W-1:0]    transfer_bytes,
	input logic [arct_pkg::CNT_W-1:0]    transfer_frames,
	input logic [arct_pkg::CNT_W-1:0]    first_part_bytes,
	input logic [arct_pkg::CNT_W-1:0]    second_part_bytes
);

	// no transfer means empty byte fields
	`ARCT_ASSERT(a_no_xfer_zero, (out_valid && status != arct_pkg::STAT_XFER) |-> (transfer_bytes == '0 && transfer_frames == '0 && first_part_bytes == '0 && second_part_bytes == '0), "non-transfer result carries byte counts")

	// split parts add up to the transfer
	`ARCT_ASSERT(a_split_sum, (out_valid && status == arct_pkg::STAT_XFER) |-> (first_part_bytes + second_part_bytes == transfer_bytes && transfer_bytes != '0), "transfer split does not match byte count")

	// one request in flight
	`ARCT_ASSERT(a_one_req, (in_valid && in_ready) |=> !in_ready, "request accepted while busy")

	`ARCT_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(transfer_bytes)), "stalled result changed")

endmodule

bind audio_ring_cursor_tracker arct_chk u_arct_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (in_ch.valid),
	.in_ready          (in_ch.ready),
	.out_valid         (out_ch.valid),
	.out_ready         (out_ch.ready),
	.status            (out_ch.status),
	.transfer_bytes    (out_ch.transfer_bytes),
	.transfer_frames   (out_ch.transfer_frames),
	.first_part_bytes  (out_ch.first_part_bytes),
	.second_part_bytes (out_ch.second_part_bytes)
);
